FILE: hdl/wpl_pkg.sv
// shared types and constants for the waypoint list prune engine
package wpl_pkg;

    // fixed field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned CAP_W   = 7;
    localparam int unsigned ENTRY_W = 7;
    localparam int unsigned WORD_W  = KIND_W + 2 * COORD_W;

    // list capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // waypoint kind that prune may drop
    localparam logic [KIND_W-1:0] KIND_REGULAR = 2'd0;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PRUNE  = 2'd2
    } cmd_t;

    // one request as seen by the sequencer
    typedef struct packed {
        cmd_t                       command;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic [KIND_W-1:0]          point_kind;
        logic [POS_W-1:0]           position;
    } req_t;

    // one result
    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] entry_count;
        logic               is_full;
        logic               is_empty;
    } rsp_t;

endpackage

FILE: hdl/wpl_req_if.sv
// request channel: command and waypoint payload with valid/ready
interface wpl_req_if
    import wpl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic [KIND_W-1:0]          point_kind;
    logic [POS_W-1:0]           position;

    modport source (
        output valid, command, coord_x, coord_y, point_kind, position,
        input  ready
    );

    modport sink (
        input  valid, command, coord_x, coord_y, point_kind, position,
        output ready
    );
endinterface

FILE: hdl/wpl_rsp_if.sv
// result channel: status and list count with valid/ready
interface wpl_rsp_if
    import wpl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ENTRY_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;

    modport source (
        output valid, ok, entry_count, is_full, is_empty,
        input  ready
    );

    modport sink (
        input  valid, ok, entry_count, is_full, is_empty,
        output ready
    );
endinterface

FILE: hdl/wpl_store.sv
// waypoint store: one write port, one read port, registered read data
module wpl_store
    import wpl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned AW          = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] store_mem [MAX_ENTRIES];
    logic [WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wpl_seq.sv
// command sequencer: insert, remove with gap closing, prune scan and compaction
module wpl_seq
    import wpl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CAP_W-1:0]  capacity,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output rsp_t              res
);

    localparam int unsigned AW    = $clog2(MAX_ENTRIES);
    localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned FW    = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COPY,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ok_reg, ok_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     iss_ptr_reg, iss_ptr_next;
    logic              iss_on_reg, iss_on_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic              filter_reg, filter_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic [FW-1:0]     cap_ext;
    logic [FW-1:0]     eff_cap;
    logic              full_now;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [AW-1:0]     pos_addr;
    logic [AW-1:0]     cur_last;
    logic              rd_keep;
    logic              rd_at_last;

    wpl_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // effective capacity and status
    always_comb
    begin
        cap_ext  = FW'(capacity);
        eff_cap  = (cap_ext > FW'(MAX_ENTRIES)) ? FW'(MAX_ENTRIES) : cap_ext;
        full_now = FW'(count_reg) >= eff_cap;
        pos_ext  = CMP_W'(req.position);
        cnt_ext  = CMP_W'(count_reg);
        pos_addr = pos_ext[AW-1:0];
        cur_last = AW'(count_reg - CW'(1));
    end

    // classify the entry returned by the store this cycle
    assign rd_keep    = mem_rdata[WORD_W-1 -: KIND_W] != KIND_REGULAR;
    assign rd_at_last = rd_addr_reg == last_reg;

    // result and handshake
    assign req_ready       = state_reg == S_IDLE;
    assign res_valid       = state_reg == S_RESP;
    assign res.ok          = ok_reg;
    assign res.entry_count = ENTRY_W'(count_reg);
    assign res.is_full     = full_now;
    assign res.is_empty    = count_reg == '0;

    // next state; reads run ahead of writes, so no entry is read and written together
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;
        iss_ptr_next = iss_ptr_reg;
        iss_on_next  = iss_on_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = iss_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        filter_next  = filter_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_ptr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = iss_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    last_next  = cur_last;
                    state_next = S_RESP;
                    unique case (req.command)
                        CMD_INSERT:
                        begin
                            ok_next = !full_now;
                            if (!full_now)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = {req.point_kind, req.coord_y, req.coord_x};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            ok_next = pos_ext < cnt_ext;
                            if (pos_ext < cnt_ext)
                            begin
                                if (pos_addr == cur_last)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                else
                                begin
                                    iss_ptr_next = pos_addr + AW'(1);
                                    iss_on_next  = 1'b1;
                                    wr_ptr_next  = pos_addr;
                                    filter_next  = 1'b0;
                                    state_next   = S_COPY;
                                end
                            end
                        end
                        CMD_PRUNE:
                        begin
                            ok_next = 1'b1;
                            if (count_reg > CW'(1))
                            begin
                                iss_ptr_next = cur_last;
                                iss_on_next  = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            // walk back from the tail looking for the anchor entry
            S_SCAN:
            begin
                if (iss_on_reg)
                begin
                    rd_pend_next = 1'b1;
                    iss_on_next  = iss_ptr_reg != '0;
                    iss_ptr_next = iss_ptr_reg - AW'(1);
                end
                if (rd_pend_reg && (rd_keep || rd_addr_reg == '0))
                begin
                    rd_pend_next = 1'b0;
                    iss_on_next  = 1'b0;
                    if (rd_at_last)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        iss_ptr_next = rd_addr_reg + AW'(1);
                        iss_on_next  = 1'b1;
                        wr_ptr_next  = rd_addr_reg + AW'(1);
                        filter_next  = 1'b1;
                        state_next   = S_COPY;
                    end
                end
            end

            // stream entries toward the head, dropping regular ones other than the tail when filtering
            S_COPY:
            begin
                if (iss_on_reg)
                begin
                    rd_pend_next = 1'b1;
                    iss_on_next  = iss_ptr_reg != last_reg;
                    iss_ptr_next = iss_ptr_reg + AW'(1);
                end
                if (rd_pend_reg)
                begin
                    if (!filter_reg || rd_keep || rd_at_last)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + AW'(1);
                    end
                    if (rd_at_last)
                    begin
                        count_next   = CW'(wr_ptr_reg) + CW'(1);
                        rd_pend_next = 1'b0;
                        iss_on_next  = 1'b0;
                        state_next   = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
            last_reg    <= '0;
            iss_ptr_reg <= '0;
            iss_on_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_addr_reg <= '0;
            wr_ptr_reg  <= '0;
            filter_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ok_reg      <= ok_next;
            last_reg    <= last_next;
            iss_ptr_reg <= iss_ptr_next;
            iss_on_reg  <= iss_on_next;
            rd_pend_reg <= rd_pend_next;
            rd_addr_reg <= rd_addr_next;
            wr_ptr_reg  <= wr_ptr_next;
            filter_reg  <= filter_next;
        end
    end

endmodule

FILE: hdl/waypoint_list_prune_engine.sv
// top level of the waypoint list prune engine
//
// usage: one request on req (command, coord_x, coord_y, point_kind, position)
// gives exactly one result on rsp (ok, entry_count, is_full, is_empty).
// the list lives in a single-port-write, single-port-read memory of
// MAX_ENTRIES entries with a registered read; requests are served one at a time.
// how each command runs before its result is valid:
//   insert, failed command, remove at the tail, prune of fewer than two
//     entries: straight from idle to the result state
//   remove at position p below the tail: the entries after p shift down, one
//     shifted entry per cycle through the memory port
//   prune of n entries: a backward scan for the anchor, then a compaction
//     pass unless the anchor is the tail, each one entry per memory read
// capacity is set through cfg_we/cfg_wdata while no request is in flight.
// reset empties the list and sets capacity to 64; no clearing pass is run.
// rsp is held in an output register: a new request is taken while an earlier
// result waits on a stalled receiver; the next result waits in the engine
// until the output register frees, and req.ready stays low meanwhile.
module waypoint_list_prune_engine
    import wpl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    wpl_req_if.sink          req,
    wpl_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic [CAP_W-1:0] cap_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    req_t             seq_req;
    logic             seq_ready;
    logic             res_valid;
    logic             res_ready;
    rsp_t             res;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // request payload into the sequencer
    assign seq_req.command    = cmd_t'(req.command);
    assign seq_req.coord_x    = req.coord_x;
    assign seq_req.coord_y    = req.coord_y;
    assign seq_req.point_kind = req.point_kind;
    assign seq_req.position   = req.position;
    assign req.ready          = seq_ready;

    wpl_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (cap_reg),
        .req_valid (req.valid),
        .req_ready (seq_ready),
        .req       (seq_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_reg.ok;
    assign rsp.entry_count = rsp_reg.entry_count;
    assign rsp.is_full     = rsp_reg.is_full;
    assign rsp.is_empty    = rsp_reg.is_empty;

    // no new request while a finished result is still in the engine
    a_no_req_during_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> !seq_ready
    ) else $error("request taken while a result is pending");

    // a result handed over shows on rsp in the next cycle
    a_result_reaches_port: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> rsp.valid
    ) else $error("handed-over result missing on rsp");

    // each request yields a single result
    a_single_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> !res_valid
    ) else $error("result repeated");

endmodule

FILE: tb/tb.sv
// testbench for the waypoint list prune engine: shadow list, random requests, result checks
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wpl_pkg::*;

    localparam int DEPTH          = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;

    // command code outside the decoded set
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one request as driven on the channel (command kept as raw bits)
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [KIND_W-1:0]  point_kind;
        logic [POS_W-1:0]   position;
    } request_t;

    // one stored waypoint
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } waypoint_t;

    // shadow copy of the list and the queue of results it predicts
    class list_shadow;
        waypoint_t   slots[DEPTH];
        int          fill;
        int          capacity;
        rsp_t        pending[$];
        int unsigned mismatches;

        function new();
            fill       = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        // capacity clamped to the store depth
        function int usable();
            return capacity > DEPTH ? DEPTH : capacity;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // keep the last non-regular entry (or head) and the tail, drop regulars between
        function void prune_regulars();
            int anchor;
            int last;
            int wr;
            if (fill <= 1)
                return;
            last   = fill - 1;
            anchor = 0;
            for (int i = last; i >= 0; i--)
            begin
                if (slots[i].kind != KIND_REGULAR)
                begin
                    anchor = i;
                    break;
                end
            end
            if (anchor == last)
                return;
            wr = anchor + 1;
            for (int i = anchor + 1; i < last; i++)
            begin
                if (slots[i].kind != KIND_REGULAR)
                begin
                    slots[wr] = slots[i];
                    wr++;
                end
            end
            slots[wr] = slots[last];
            fill      = wr + 1;
        endfunction

        // apply one accepted request and queue the status it must produce
        function void apply_command(request_t c);
            logic ok;
            rsp_t status;
            case (c.command)
                CMD_INSERT:
                begin
                    ok = (fill < usable());
                    if (ok)
                    begin
                        slots[fill] = {c.point_kind, c.coord_y, c.coord_x};
                        fill++;
                    end
                end
                CMD_REMOVE:
                begin
                    ok = (int'(c.position) < fill);
                    if (ok)
                    begin
                        for (int i = int'(c.position); i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                end
                CMD_PRUNE:
                begin
                    prune_regulars();
                    ok = 1'b1;
                end
                default:
                    ok = 1'b0;
            endcase
            status.ok          = ok;
            status.entry_count = ENTRY_W'(fill);
            status.is_full     = (fill >= usable());
            status.is_empty    = (fill == 0);
            pending.push_back(status);
        endfunction

        // compare an accepted result with the oldest predicted status
        function void check_status(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected result ok=%0d count=%0d full=%0d empty=%0d",
                               got.ok, got.entry_count, got.is_full, got.is_empty));
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok || got.entry_count !== want.entry_count ||
                got.is_full !== want.is_full || got.is_empty !== want.is_empty)
                flag($sformatf({"result mismatch: expected ok=%0d count=%0d full=%0d ",
                                "empty=%0d, got ok=%0d count=%0d full=%0d empty=%0d"},
                               want.ok, want.entry_count, want.is_full, want.is_empty,
                               got.ok, got.entry_count, got.is_full, got.is_empty));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               tx_idle;
    int               rx_idle;
    int               quiet_cycles;
    list_shadow       shadow;

    wpl_req_if req_ch ();
    wpl_rsp_if rsp_ch ();

    waypoint_list_prune_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // receiver stalls
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_status(rsp_t'({rsp_ch.ok, rsp_ch.entry_count,
                                        rsp_ch.is_full, rsp_ch.is_empty}));
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // present one request, with random gaps, and wait until it is taken
    task automatic send_command(input request_t c);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.command    <= c.command;
        req_ch.coord_x    <= c.coord_x;
        req_ch.coord_y    <= c.coord_y;
        req_ch.point_kind <= c.point_kind;
        req_ch.position   <= c.position;
        req_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow.apply_command(c);
        @(negedge clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input int x, input int y,
                         input int kind, input int pos);
        request_t c;
        c.command    = cmd;
        c.coord_x    = COORD_W'(x);
        c.coord_y    = COORD_W'(y);
        c.point_kind = KIND_W'(kind);
        c.position   = POS_W'(pos);
        send_command(c);
    endtask

    // drain all results, then write the capacity register
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we         <= 1'b0;
        shadow.capacity = value;
    endtask

    // random requests in chunks, each chunk with its own capacity and insert mix
    task automatic run_random(input int items);
        int               done;
        int               chunk;
        int               insert_pct;
        logic [CAP_W-1:0] cap;
        request_t         c;
        done = 0;
        while (done < items)
        begin
            case ($urandom_range(0, 9))
                0:       cap = '0;
                1:       cap = 7'd1;
                2:       cap = '1;
                3, 4:    cap = CAP_W'($urandom_range(2, 12));
                5:       cap = CAP_W'($urandom_range(0, 127));
                default: cap = CAP_W'(DEPTH);
            endcase
            write_capacity(cap);
            case ($urandom_range(0, 3))
                0:       insert_pct = 30;
                1:       insert_pct = 60;
                2:       insert_pct = 90;
                default: insert_pct = 97;
            endcase
            chunk = $urandom_range(30, 60);
            for (int k = 0; k < chunk && done < items; k++)
            begin
                c.coord_x    = COORD_W'($urandom_range(0, 65535));
                c.coord_y    = COORD_W'($urandom_range(0, 65535));
                c.point_kind = ($urandom_range(0, 99) < 55) ? KIND_REGULAR
                                                            : KIND_W'($urandom_range(1, 3));
                c.position   = POS_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < insert_pct)
                    c.command = CMD_INSERT;
                else
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8:   c.command = CMD_REMOVE;
                        9, 10, 11, 12, 13, 14, 15, 16: c.command = CMD_PRUNE;
                        default:                     c.command = CMD_UNUSED;
                    endcase
                end
                // mostly hit a stored entry on remove
                if (c.command == CMD_REMOVE && shadow.fill > 0 && $urandom_range(0, 99) < 80)
                    c.position = POS_W'($urandom_range(0, shadow.fill - 1));
                send_command(c);
                done++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        shadow            = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_INSERT;
        req_ch.coord_x    = '0;
        req_ch.coord_y    = '0;
        req_ch.point_kind = KIND_REGULAR;
        req_ch.position   = '0;
        rsp_ch.ready      = 1'b0;
        quiet_cycles      = 0;
        tx_idle           = 16;
        rx_idle           = 87;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, unused command, field extremes, full list
        write_capacity(7'd4);
        issue(CMD_PRUNE,  0, 0, 0, 0);
        issue(CMD_REMOVE, 0, 0, 0, 0);
        issue(CMD_UNUSED, 0, 0, 0, 0);
        issue(CMD_INSERT, -32768, 32767, 1, 0);
        issue(CMD_PRUNE,  0, 0, 0, 0);
        issue(CMD_INSERT, 32767, -32768, 0, 63);
        issue(CMD_INSERT, 0, -1, 0, 0);
        issue(CMD_INSERT, 1, 1, 2, 0);
        issue(CMD_INSERT, -1, 0, 3, 0);
        // prune with non-regular tail, removes out of range, remove at tail
        issue(CMD_PRUNE,  0, 0, 0, 0);
        issue(CMD_REMOVE, 0, 0, 0, 63);
        issue(CMD_REMOVE, 0, 0, 0, 4);
        issue(CMD_REMOVE, 0, 0, 0, 3);
        // prune anchored on the start point, then anchored on the head
        issue(CMD_PRUNE,  0, 0, 0, 0);
        issue(CMD_REMOVE, 0, 0, 0, 0);
        issue(CMD_INSERT, 5, 5, 0, 0);
        issue(CMD_INSERT, 6, 6, 0, 0);
        issue(CMD_PRUNE,  0, 0, 0, 0);
        // capacity below count, zero capacity, capacity above depth
        write_capacity(7'd1);
        issue(CMD_INSERT, 2, 2, 1, 0);
        issue(CMD_REMOVE, 0, 0, 0, 1);
        write_capacity('0);
        issue(CMD_INSERT, 3, 3, 2, 0);
        issue(CMD_PRUNE,  0, 0, 0, 0);
        write_capacity('1);
        issue(CMD_INSERT, 4, 4, 3, 0);

        run_random(170);
        tx_idle = 87;
        rx_idle = 16;
        run_random(170);
        tx_idle = 0;
        rx_idle = 0;
        run_random(170);

        // wait out the last results and any stray ones
        req_ch.valid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
